// ===== src/repeated_subarray_removal_top_assert.svh =====
// assertion macros for the repeated sub-array removal block
`ifndef REPEATED_SUBARRAY_REMOVAL_TOP_ASSERT_SVH
`define REPEATED_SUBARRAY_REMOVAL_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define RSR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define RSR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/rsr_pkg.sv =====
// ----------------------------------------------------------------------------
// rsr_pkg
// Shared types for the repeated sub-array removal block.
// ----------------------------------------------------------------------------
`default_nettype none

package rsr_pkg;

	// sequencer states
	typedef enum logic [3:0] {
		ST_LOAD,
		ST_PASS,
		ST_CHECK,
		ST_MRD,
		ST_MCMP,
		ST_CRD,
		ST_CWR,
		ST_ORD,
		ST_OUT,
		ST_EMPTY
	} state_t;

	// input operation codes
	localparam logic OP_PATTERN = 1'b0;
	localparam logic OP_DATA    = 1'b1;

endpackage

`default_nettype wire

// ===== src/repeated_subarray_removal_top.sv =====
// ----------------------------------------------------------------------------
// repeated_subarray_removal_top
// Loads a pattern and a data array, removes pattern occurrences pass by pass
// until a pass removes nothing, then streams out the surviving elements.
// ----------------------------------------------------------------------------
// Loading: one element per cycle in ST_LOAD (stalled otherwise), result-free.
// Removal: each scan step checks, then either reads and compares pattern elements or
// copies a kept element (read, then write); each pass begins with a set-up step.
// Output: per result a memory read, then presentation.
// Reset: counts, flags and sequencer clear asynchronously; memories do not.
`default_nettype none

module repeated_subarray_removal_top #(
	parameter int DATA_DEPTH    = 64,
	parameter int PATTERN_DEPTH = 16,
	parameter int VALUE_WIDTH   = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        operation,
	input  wire logic signed [31:0] value,
	input  wire logic        last,
	output logic             res_valid,
	input  wire logic        res_stall,
	output logic signed [31:0] value_res,
	output logic             last_res,
	output logic             empty_res,
	output logic             overflow
);
	import rsr_pkg::*;

	localparam int AW  = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
	localparam int PAW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
	localparam int CW  = $clog2(DATA_DEPTH + 1);
	localparam int PCW = $clog2(PATTERN_DEPTH + 1);
	localparam int SW  = ((CW > PCW) ? CW : PCW) + 1;

	state_t state_q, state_d;

	logic [CW-1:0]  n_q, r_q, w_q, src_q;
	logic [PCW-1:0] plen_q;
	logic [PAW-1:0] j_q;
	logic           removed_q, pdone_q, overflow_q;

	logic                   d_we, p_we;
	logic [AW-1:0]          d_waddr, d_raddr;
	logic [PAW-1:0]         p_waddr;
	logic [VALUE_WIDTH-1:0] d_wdata, d_rdata, p_rdata, v_ext;
	logic [31:0]            value_u;

	logic [SW-1:0]  r_plus_p, r_plus_j;
	logic [PCW-1:0] p_wptr;
	logic           in_acc, out_acc, match_end, data_room, pat_room;

	// data and pattern memories
	rsr_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DATA_DEPTH), .AW(AW)) u_data (
		.clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
		.raddr(d_raddr), .rdata(d_rdata)
	);

	rsr_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(PATTERN_DEPTH), .AW(PAW)) u_pat (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(v_ext),
		.raddr(j_q), .rdata(p_rdata)
	);

	// helper arithmetic
	assign value_u   = value;
	assign v_ext     = VALUE_WIDTH'(value_u);
	assign r_plus_p  = SW'(r_q) + SW'(plen_q);
	assign r_plus_j  = SW'(r_q) + SW'(j_q);
	assign match_end = (PCW'(j_q) + PCW'(1)) == plen_q;
	assign p_wptr    = pdone_q ? '0 : plen_q;
	assign data_room = n_q < CW'(DATA_DEPTH);
	assign pat_room  = p_wptr < PCW'(PATTERN_DEPTH);
	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = res_valid && !res_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (in_acc && operation == OP_DATA && last) begin
					state_d = (plen_q != '0) ? ST_PASS : ST_ORD;
				end
			end
			ST_PASS:  state_d = ST_CHECK;
			ST_CHECK: begin
				if (r_plus_p <= SW'(n_q)) begin
					state_d = ST_MRD;
				end else if (r_q < n_q) begin
					state_d = ST_CRD;
				end else begin
					state_d = removed_q ? ST_PASS : ST_ORD;
				end
			end
			ST_MRD:   state_d = ST_MCMP;
			ST_MCMP: begin
				if (d_rdata != p_rdata) begin
					state_d = ST_CRD;
				end else if (match_end) begin
					state_d = (r_plus_p < SW'(n_q)) ? ST_CRD : ST_CHECK;
				end else begin
					state_d = ST_MRD;
				end
			end
			ST_CRD:   state_d = ST_CWR;
			ST_CWR:   state_d = ST_CHECK;
			ST_ORD:   state_d = (n_q == '0) ? ST_EMPTY : ST_OUT;
			ST_OUT: begin
				if (out_acc) begin
					state_d = ((r_q + CW'(1)) == n_q) ? ST_LOAD : ST_ORD;
				end
			end
			ST_EMPTY: begin
				if (out_acc) begin
					state_d = ST_LOAD;
				end
			end
			default:  state_d = ST_LOAD;
		endcase
	end

	// memory control and handshake outputs
	always_comb begin
		in_stall  = 1'b1;
		res_valid = 1'b0;
		empty_res = 1'b0;
		last_res  = 1'b0;
		value_res = '0;
		d_we      = 1'b0;
		p_we      = 1'b0;
		d_waddr   = n_q[AW-1:0];
		d_wdata   = v_ext;
		d_raddr   = r_plus_j[AW-1:0];
		p_waddr   = p_wptr[PAW-1:0];
		unique case (state_q)
			ST_LOAD: begin
				in_stall = 1'b0;
				d_we     = in_acc && operation == OP_DATA && data_room;
				p_we     = in_acc && operation == OP_PATTERN && pat_room;
			end
			ST_CRD:  d_raddr = src_q[AW-1:0];
			ST_CWR: begin
				d_we    = 1'b1;
				d_waddr = w_q[AW-1:0];
				d_wdata = d_rdata;
			end
			ST_ORD:  d_raddr = r_q[AW-1:0];
			ST_OUT: begin
				res_valid = 1'b1;
				value_res = 32'(d_rdata);
				last_res  = (r_q + CW'(1)) == n_q;
			end
			ST_EMPTY: begin
				res_valid = 1'b1;
				empty_res = 1'b1;
				last_res  = 1'b1;
			end
			default: ;
		endcase
		overflow = overflow_q;
	end

	// sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			n_q        <= '0;
			r_q        <= '0;
			w_q        <= '0;
			src_q      <= '0;
			j_q        <= '0;
			plen_q     <= '0;
			removed_q  <= 1'b0;
			pdone_q    <= 1'b0;
			overflow_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_LOAD: begin
					r_q <= '0;
					if (in_acc) begin
						if (operation == OP_PATTERN) begin
							if (pat_room) begin
								plen_q <= p_wptr + PCW'(1);
							end else begin
								plen_q     <= p_wptr;
								overflow_q <= 1'b1;
							end
							pdone_q <= last;
						end else if (data_room) begin
							n_q <= n_q + CW'(1);
						end else begin
							overflow_q <= 1'b1;
						end
					end
				end
				ST_PASS: begin
					r_q       <= '0;
					w_q       <= '0;
					removed_q <= 1'b0;
				end
				ST_CHECK: begin
					j_q   <= '0;
					src_q <= r_q;
					if (!(r_plus_p <= SW'(n_q)) && !(r_q < n_q)) begin
						n_q <= w_q;
						r_q <= '0;
					end
				end
				ST_MCMP: begin
					if (d_rdata != p_rdata) begin
						src_q <= r_q;
					end else if (match_end) begin
						removed_q <= 1'b1;
						src_q     <= r_plus_p[CW-1:0];
						r_q       <= r_plus_p[CW-1:0];
					end else begin
						j_q <= j_q + PAW'(1);
					end
				end
				ST_CWR: begin
					w_q <= w_q + CW'(1);
					r_q <= src_q + CW'(1);
				end
				ST_OUT: begin
					if (out_acc) begin
						if ((r_q + CW'(1)) == n_q) begin
							n_q        <= '0;
							r_q        <= '0;
							overflow_q <= 1'b0;
						end else begin
							r_q <= r_q + CW'(1);
						end
					end
				end
				ST_EMPTY: begin
					if (out_acc) begin
						overflow_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== src/rsr_ram.sv =====
// ----------------------------------------------------------------------------
// rsr_ram
// Single-port-write, single-port-read synchronous memory, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rsr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== src/rsr_checker.sv =====
// ----------------------------------------------------------------------------
// rsr_checker
// Port-level checks on the result channel of the removal block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "repeated_subarray_removal_top_assert.svh"

module rsr_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_stall,
	input wire logic        res_valid,
	input wire logic        res_stall,
	input wire logic [31:0] value_res,
	input wire logic        last_res,
	input wire logic        empty_res
);

	// no new input transaction while results are being delivered
	`RSR_ASSERT_NOW(a_stall_during_out, res_valid, in_stall, "input taken during output")

	// empty result is a single zero-valued final transaction
	`RSR_ASSERT_NOW(a_empty_form, res_valid && empty_res, last_res && value_res == '0,
		"malformed empty result")

	// a stalled result holds its value
	`RSR_ASSERT_NEXT(a_hold, res_valid && res_stall, res_valid && $stable(value_res),
		"stalled result changed")

endmodule

bind repeated_subarray_removal_top rsr_checker u_rsr_checker (.*);

`default_nettype wire

// ===== dv/tb_repeated_subarray_removal_top.sv =====
// ----------------------------------------------------------------------------
// tb_repeated_subarray_removal_top
// Self-checking bench for the repeated sub-array removal block: drives pattern
// and data transactions with random gaps and output stalls, predicts the
// survivors of repeated removal passes and compares every result in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_repeated_subarray_removal_top;
	import rsr_pkg::*;

	localparam int DATA_DEPTH    = 64;
	localparam int PATTERN_DEPTH = 16;
	localparam int STALL_LIMIT   = 200000;

	typedef struct packed {
		logic               op;
		logic signed [31:0] val;
		logic               lst;
	} load_t;

	typedef struct packed {
		logic signed [31:0] val;
		logic               lst;
		logic               emp;
		logic               ovf;
	} survivor_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic operation;
	logic signed [31:0] value;
	logic last;
	logic res_valid;
	logic res_stall;
	logic signed [31:0] value_res;
	logic last_res;
	logic empty_res;
	logic overflow;

	repeated_subarray_removal_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .value(value), .last(last),
		.res_valid(res_valid), .res_stall(res_stall),
		.value_res(value_res), .last_res(last_res),
		.empty_res(empty_res), .overflow(overflow)
	);

	// predictor state
	logic [31:0] pat_mem [PATTERN_DEPTH];
	int          pat_len = 0;
	logic        pat_closed = 1'b0;
	logic [31:0] arr_mem [DATA_DEPTH];
	int          arr_len = 0;
	logic        ovf_seen = 1'b0;

	load_t     pending_loads[$];
	survivor_t expected_survivors[$];

	int  mismatches = 0;
	int  results_seen = 0;
	int  runs_done = 0;
	int  idle_cycles = 0;
	bit  in_taken = 1'b0;
	bit  calm = 1'b0;
	int  src_gap;
	int  snk_gap;

	// pattern words queued for the stimulus
	logic [31:0] stim_pat [PATTERN_DEPTH];

	// one removal pass, returns whether anything was removed
	function automatic bit strip_pass();
		bit hit;
		bit ok;
		int i;
		int j;
		int k;
		hit = 0;
		i = 0;
		while (i + pat_len <= arr_len) begin
			ok = 1;
			for (j = 0; j < pat_len; j++)
				if (arr_mem[i + j] != pat_mem[j])
					ok = 0;
			if (ok) begin
				for (k = i; k + pat_len < arr_len; k++)
					arr_mem[k] = arr_mem[k + pat_len];
				arr_len -= pat_len;
				hit = 1;
			end
			i++;
		end
		return hit;
	endfunction

	// update the predictor with one accepted transaction
	task automatic predict_load(input load_t t);
		survivor_t s;
		int i;
		if (t.op == OP_PATTERN) begin
			if (pat_closed) begin
				pat_len = 0;
				pat_closed = 0;
			end
			if (pat_len < PATTERN_DEPTH) begin
				pat_mem[pat_len] = t.val;
				pat_len++;
			end else
				ovf_seen = 1;
			if (t.lst)
				pat_closed = 1;
		end else begin
			if (arr_len < DATA_DEPTH) begin
				arr_mem[arr_len] = t.val;
				arr_len++;
			end else
				ovf_seen = 1;
			if (t.lst) begin
				if (pat_len > 0 && pat_len <= arr_len)
					while (strip_pass()) ;
				if (arr_len == 0) begin
					s = '{val: 0, lst: 1, emp: 1, ovf: ovf_seen};
					expected_survivors.push_back(s);
				end else
					for (i = 0; i < arr_len; i++) begin
						s = '{val: arr_mem[i], lst: (i == arr_len - 1), emp: 0,
							ovf: ovf_seen};
						expected_survivors.push_back(s);
					end
				arr_len = 0;
				ovf_seen = 0;
				runs_done++;
			end
		end
	endtask

	task automatic queue_load(input logic op, input logic [31:0] v, input logic l);
		pending_loads.push_back('{op: op, val: v, lst: l});
	endtask

	// one word, mostly from a small alphabet, so matches are frequent
	function automatic logic [31:0] pick_word(input int alpha);
		case ($urandom_range(0, 9))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom;
			default: return $urandom_range(0, alpha - 1);
		endcase
	endfunction

	// data for one job, with copies of the current pattern planted
	task automatic queue_job_data(input int plen, input int alpha);
		int n;
		int i;
		int j;
		n = $urandom_range(1, 12);
		for (i = 0; i < n; i++) begin
			if ($urandom_range(0, 1) == 0)
				for (j = 0; j < plen; j++)
					queue_load(OP_DATA, stim_pat[j], 1'b0);
			else
				queue_load(OP_DATA, pick_word(alpha), 1'b0);
		end
		queue_load(OP_DATA, pick_word(alpha), 1'b1);
	endtask

	// clock
	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// driver
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			operation <= 0;
			value <= 0;
			last <= 0;
			src_gap <= 0;
		end else if (!in_valid || in_taken) begin
			if (src_gap > 0) begin
				in_valid <= 0;
				src_gap <= src_gap - 1;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				in_valid <= 0;
				src_gap <= $urandom_range(0, 7);
			end else if (pending_loads.size() > 0) begin
				in_valid <= 1;
				operation <= pending_loads[0].op;
				value <= pending_loads[0].val;
				last <= pending_loads[0].lst;
				void'(pending_loads.pop_front());
			end else
				in_valid <= 0;
		end
	end

	// stall generator on the result side
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 0;
			snk_gap <= 0;
		end else if (snk_gap > 0) begin
			res_stall <= 1;
			snk_gap <= snk_gap - 1;
		end else if (!calm && $urandom_range(0, 4) == 0) begin
			res_stall <= 1;
			snk_gap <= $urandom_range(0, 7);
		end else
			res_stall <= 0;
	end

	// monitor: predict on input transactions, check output transactions
	always @(posedge clk) begin
		survivor_t got;
		survivor_t want;
		bit seen;
		seen = 0;
		if (!arst_n) begin
			idle_cycles <= 0;
			in_taken <= 0;
		end else begin
			in_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				predict_load('{op: operation, val: value, lst: last});
				seen = 1;
			end
			if (res_valid && !res_stall) begin
				seen = 1;
				results_seen++;
				got = '{val: value_res, lst: last_res, emp: empty_res, ovf: overflow};
				if (expected_survivors.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: value %h last %b empty %b ovf %b",
							got.val, got.lst, got.emp, got.ovf);
				end else begin
					want = expected_survivors.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp %h/%b/%b/%b got %h/%b/%b/%b",
								want.val, want.lst, want.emp, want.ovf,
								got.val, got.lst, got.emp, got.ovf);
					end
				end
			end
			idle_cycles <= seen ? 0 : idle_cycles + 1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog expired with %0d results outstanding",
				expected_survivors.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// stimulus and end of run
	initial begin
		int i;
		int plen;
		int alpha;
		int wait_cycles;
		arst_n = 0;

		// directed: empty pattern passthrough, two data elements
		queue_load(OP_DATA, 32'h7fffffff, 1'b0);
		queue_load(OP_DATA, 32'h80000000, 1'b1);
		// pattern A,B; data forms nested copies that vanish over several passes
		queue_load(OP_PATTERN, 32'h80000000, 1'b0);
		queue_load(OP_PATTERN, 32'hffffffff, 1'b1);
		queue_load(OP_DATA, 32'h80000000, 1'b0);
		queue_load(OP_DATA, 32'h80000000, 1'b0);
		queue_load(OP_DATA, 32'hffffffff, 1'b0);
		queue_load(OP_DATA, 32'hffffffff, 1'b1);
		// pattern longer than data: passthrough
		queue_load(OP_DATA, 32'h80000000, 1'b1);
		// new pattern, left open; data overflows the store and all goes
		queue_load(OP_PATTERN, 32'h00000005, 1'b0);
		for (i = 0; i < DATA_DEPTH + 2; i++)
			queue_load(OP_DATA, 32'h00000005, i == DATA_DEPTH + 1);
		// pattern words extend the open pattern and overflow its store, then data shorter than the pattern passes through
		for (i = 0; i < PATTERN_DEPTH + 2; i++)
			queue_load(OP_PATTERN, i, i == PATTERN_DEPTH + 1);
		queue_load(OP_DATA, 32'h00000000, 1'b0);
		queue_load(OP_DATA, 32'h00000001, 1'b1);

		// random jobs with a small alphabet so that patterns recur
		for (i = 0; i < PATTERN_DEPTH; i++)
			stim_pat[i] = i;
		while (pending_loads.size() < 360) begin
			alpha = $urandom_range(2, 4);
			plen = $urandom_range(1, 4);
			if ($urandom_range(0, 9) == 0) begin
				// noise: random ops and values
				queue_load(1'($urandom_range(0, 1)), $urandom, 1'b0);
				queue_load(OP_DATA, $urandom, 1'b1);
			end else begin
				for (i = 0; i < plen; i++)
					stim_pat[i] = pick_word(alpha);
				for (i = 0; i < plen; i++)
					queue_load(OP_PATTERN, stim_pat[i], i == plen - 1);
				queue_job_data(plen, alpha);
			end
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// last stretch runs without gaps or stalls
		wait (pending_loads.size() < 60);
		calm = 1;
		wait (pending_loads.size() == 0 && !in_valid);
		wait (expected_survivors.size() == 0);
		wait_cycles = 0;
		while (wait_cycles < 400) begin
			@(posedge clk);
			wait_cycles++;
		end
		$display("ran %0d data runs, checked %0d results", runs_done, results_seen);
		if (mismatches == 0 && expected_survivors.size() == 0)
			$display("RESULT: OK");
		else begin
			$display("%0d mismatches", mismatches);
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
